FILE: rtl/core/ots_pkg.sv
// Shared types and constants for the ordered touch stroke detector.
package ots_pkg;

   localparam int TimeWidth  = 32;
   localparam int LevelWidth = 2;
   localparam int SpanWidth  = 16;
   localparam int ZoneCount  = 3;
   localparam int CsrIndexWidth = 2;

   localparam logic [LevelWidth-1:0] PeakLevelReset    = 2'd3;
   localparam logic [SpanWidth-1:0]  GapTimeReset      = 16'd600;
   localparam logic [SpanWidth-1:0]  CooldownTimeReset = 16'd4000;

   localparam logic [CsrIndexWidth-1:0] CsrPeakLevel    = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrGapTime      = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrCooldownTime = 2'd2;

   localparam logic [ZoneCount-1:0] AllZonesHit = {ZoneCount{1'b1}};

   typedef struct packed {
      logic [TimeWidth-1:0]  sample_time;
      logic [LevelWidth-1:0] front_level;
      logic [LevelWidth-1:0] middle_level;
      logic [LevelWidth-1:0] rear_level;
   } req_payload_type;

   typedef struct packed {
      logic stroke_found;
      logic direction;
      logic sample_ignored;
   } rsp_payload_type;

   typedef struct packed {
      logic [LevelWidth-1:0] peak_level;
      logic [SpanWidth-1:0]  gap_time;
      logic [SpanWidth-1:0]  cooldown_time;
   } cfg_type;

   // True when x lies strictly before y in wrapping time.
   function automatic logic earlier(input logic [TimeWidth-1:0] x,
                                    input logic [TimeWidth-1:0] y);
      logic [TimeWidth-1:0] diff;
      diff = x - y;
      return diff[TimeWidth-1];
   endfunction

endpackage

FILE: rtl/core/ordered_touch_stroke_detector_top.sv
// Top level of the ordered touch stroke detector.
// The block takes one touch sample per clock cycle and returns one result per
// sample, after the sample passes from the input register through the decision
// logic into the result register. Each result reports whether the sample
// completed an ordered front-to-back or back-to-front stroke, its direction, and
// whether it fell inside the cooldown that follows a stroke. The gesture state
// updates once per sample, so a new sample is accepted every cycle while the
// receiver keeps taking results. Configuration registers should be written
// only while no transaction is in flight.
module ordered_touch_stroke_detector_top import ots_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_payload_type          req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_payload_type          rsp_payload,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [SpanWidth-1:0]     csr_write_data
);

   cfg_type         cfg_ff, cfg_in;
   logic            advance;
   logic            held_valid;
   req_payload_type held_payload;
   rsp_payload_type core_result;
   logic            fire;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CsrPeakLevel:    cfg_in.peak_level    = csr_write_data[LevelWidth-1:0];
            CsrGapTime:      cfg_in.gap_time      = csr_write_data;
            CsrCooldownTime: cfg_in.cooldown_time = csr_write_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.peak_level    <= PeakLevelReset;
         cfg_ff.gap_time      <= GapTimeReset;
         cfg_ff.cooldown_time <= CooldownTimeReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign fire = held_valid & advance;

   ots_input_stage u_input (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .advance      (advance),
      .held_valid   (held_valid),
      .held_payload (held_payload)
   );

   ots_stroke_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .sample (held_payload),
      .cfg    (cfg_ff),
      .result (core_result)
   );

   ots_output_stage u_output (
      .clock        (clock),
      .reset        (reset),
      .load_valid   (held_valid),
      .load_payload (core_result),
      .advance      (advance),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload)
   );

endmodule

FILE: rtl/core/ots_input_stage.sv
// Input register that holds one incoming transaction until the core takes it.
module ots_input_stage import ots_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   input  logic            advance,
   output logic            held_valid,
   output req_payload_type held_payload
);

   logic            valid_ff, valid_in;
   req_payload_type payload_ff, payload_in;
   logic            load;

   assign req_stall = valid_ff & ~advance;
   assign load      = req_valid & ~req_stall;

   always_comb begin
      valid_in   = valid_ff;
      payload_in = payload_ff;
      if (advance) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in   = 1'b1;
         payload_in = req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      payload_ff <= payload_in;
   end

   assign held_valid   = valid_ff;
   assign held_payload = payload_ff;

endmodule

FILE: rtl/core/ots_stroke_core.sv
// Gesture state and the per-sample cooldown, gap, hit and order decisions.
module ots_stroke_core import ots_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  req_payload_type sample,
   input  cfg_type         cfg,
   output rsp_payload_type result
);

   logic [TimeWidth-1:0] hit_time_ff [ZoneCount];
   logic [TimeWidth-1:0] hit_time_in [ZoneCount];
   logic [ZoneCount-1:0] hit_valid_ff, hit_valid_in;
   logic [TimeWidth-1:0] last_active_ff, last_active_in;
   logic [TimeWidth-1:0] next_allowed_ff, next_allowed_in;
   logic                 cooling_ff, cooling_in;

   logic [TimeWidth-1:0]  now;
   logic [LevelWidth-1:0] lvl [ZoneCount];
   logic [TimeWidth-1:0]  quiet;
   logic [ZoneCount-1:0]  valid_after_gap;
   logic                  fwd, rev;

   assign now    = sample.sample_time;
   assign lvl[0] = sample.front_level;
   assign lvl[1] = sample.middle_level;
   assign lvl[2] = sample.rear_level;
   assign quiet  = now - last_active_ff;

   always_comb begin
      hit_time_in     = hit_time_ff;
      hit_valid_in    = hit_valid_ff;
      last_active_in  = last_active_ff;
      next_allowed_in = next_allowed_ff;
      cooling_in      = cooling_ff;
      result          = '0;
      valid_after_gap = hit_valid_ff;
      fwd             = 1'b0;
      rev             = 1'b0;
      if (cooling_ff && earlier(now, next_allowed_ff)) begin
         result.sample_ignored = 1'b1;
      end else begin
         cooling_in = 1'b0;
         if (quiet > {{(TimeWidth-SpanWidth){1'b0}}, cfg.gap_time}) begin
            valid_after_gap = '0;
         end
         if ((sample.front_level | sample.middle_level | sample.rear_level) != '0) begin
            last_active_in = now;
         end
         hit_valid_in = valid_after_gap;
         for (int k = 0; k < ZoneCount; k++) begin
            if (lvl[k] >= cfg.peak_level && !valid_after_gap[k]) begin
               hit_time_in[k]  = now;
               hit_valid_in[k] = 1'b1;
            end
         end
         if (hit_valid_in == AllZonesHit) begin
            fwd = !earlier(hit_time_in[1], hit_time_in[0])
                && !earlier(hit_time_in[2], hit_time_in[1])
                && earlier(hit_time_in[0], hit_time_in[2]);
            rev = !earlier(hit_time_in[0], hit_time_in[1])
                && !earlier(hit_time_in[1], hit_time_in[2])
                && earlier(hit_time_in[2], hit_time_in[0]);
            hit_valid_in = '0;
            if (fwd || rev) begin
               result.stroke_found = 1'b1;
               result.direction    = ~fwd;
               last_active_in      = '0;
               next_allowed_in     = now + {{(TimeWidth-SpanWidth){1'b0}}, cfg.cooldown_time};
               cooling_in          = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_valid_ff    <= '0;
         last_active_ff  <= '0;
         next_allowed_ff <= '0;
         cooling_ff      <= 1'b0;
      end else if (fire) begin
         hit_valid_ff    <= hit_valid_in;
         last_active_ff  <= last_active_in;
         next_allowed_ff <= next_allowed_in;
         cooling_ff      <= cooling_in;
      end
      if (fire) begin
         hit_time_ff <= hit_time_in;
      end
   end

endmodule

FILE: rtl/core/ots_output_stage.sv
// Result register that presents one transaction until the receiver takes it.
module ots_output_stage import ots_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            load_valid,
   input  rsp_payload_type load_payload,
   output logic            advance,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic            valid_ff, valid_in;
   rsp_payload_type payload_ff, payload_in;

   assign advance = ~valid_ff | ~rsp_stall;

   always_comb begin
      valid_in   = valid_ff;
      payload_in = payload_ff;
      if (advance) begin
         valid_in   = load_valid;
         payload_in = load_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      payload_ff <= payload_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

endmodule

FILE: rtl/core/ots_checker.sv
// Port-level checks for the ordered touch stroke detector and their binding.
module ots_checker import ots_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // A stroke and an ignored sample never coincide.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.stroke_found && rsp_payload.sample_ignored))
      else $error("stroke reported on an ignored sample");

   // Direction is only meaningful with a stroke.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.stroke_found |-> !rsp_payload.direction)
      else $error("direction set without a stroke");

   // A fresh result follows an accepted transaction through the input and result registers.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a matching transaction");

endmodule

bind ordered_touch_stroke_detector_top ots_checker u_ots_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

FILE: tb/ordered_touch_stroke_detector_top_tb.sv
// Self-checking testbench for the ordered touch stroke detector top level.
module ordered_touch_stroke_detector_top_tb;
   import ots_pkg::*;

   localparam int CycleLimit = 200_000;
   localparam int PhaseCount = 8;
   localparam int LiveTarget = 112;
   localparam int ScriptRows = 22;

   typedef struct {
      logic [TimeWidth-1:0]  at_ms;
      logic [LevelWidth-1:0] front;
      logic [LevelWidth-1:0] middle;
      logic [LevelWidth-1:0] rear;
      logic                  known;
      rsp_payload_type       outcome;
   } script_row_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   req_payload_type          req_payload;
   logic                     rsp_valid;
   logic                     rsp_stall;
   rsp_payload_type          rsp_payload;
   logic                     csr_write_enable;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [SpanWidth-1:0]     csr_write_data;

   logic [LevelWidth-1:0] peak_lvl;
   logic [SpanWidth-1:0]  gap_ms;
   logic [SpanWidth-1:0]  cool_ms;
   logic [TimeWidth-1:0]  zone_time [ZoneCount];
   logic [ZoneCount-1:0]  zone_hit;
   logic [TimeWidth-1:0]  last_touch;
   logic [TimeWidth-1:0]  cool_until;
   logic                  cooling;

   rsp_payload_type pending_verdicts [$];
   rsp_payload_type oldest_verdict;
   int              mismatch_count = 0;
   int              result_count = 0;
   int              cycle_count = 0;
   int              live_count = 0;
   int              idle_pct = 0;
   int              stall_pct = 0;
   int              hold_left = 0;
   logic            hold_request = 1'b0;

   logic [LevelWidth-1:0] peak_plan [PhaseCount] = '{2'd1, 2'd2, 2'd0, 2'd3,
                                                     2'd1, 2'd3, 2'd2, 2'd0};
   logic [SpanWidth-1:0]  gap_plan [PhaseCount] = '{16'd0, 16'd65535, 16'd1000, 16'd600,
                                                    16'd300, 16'd65535, 16'd50, 16'd0};
   logic [SpanWidth-1:0]  cool_plan [PhaseCount] = '{16'd0, 16'd65535, 16'd100, 16'd4000,
                                                     16'd0, 16'd1, 16'd20000, 16'd65535};

   script_row_type opening_script [ScriptRows] = '{
      '{32'd0,          2'd0, 2'd0, 2'd0, 1'b1, 3'b000},
      '{32'd100,        2'd1, 2'd1, 2'd1, 1'b1, 3'b000},
      '{32'd200,        2'd3, 2'd0, 2'd0, 1'b0, 3'b000},
      '{32'd300,        2'd0, 2'd3, 2'd0, 1'b0, 3'b000},
      '{32'd400,        2'd0, 2'd0, 2'd3, 1'b1, 3'b100},
      '{32'd1000,       2'd3, 2'd3, 2'd3, 1'b1, 3'b001},
      '{32'd4399,       2'd0, 2'd0, 2'd3, 1'b1, 3'b001},
      '{32'd4400,       2'd0, 2'd0, 2'd3, 1'b0, 3'b000},
      '{32'd4500,       2'd0, 2'd2, 2'd0, 1'b0, 3'b000},
      '{32'd4600,       2'd0, 2'd3, 2'd0, 1'b0, 3'b000},
      '{32'd4700,       2'd3, 2'd0, 2'd0, 1'b1, 3'b110},
      '{32'd8700,       2'd3, 2'd3, 2'd3, 1'b1, 3'b000},
      '{32'd8800,       2'd3, 2'd0, 2'd0, 1'b0, 3'b000},
      '{32'd9401,       2'd0, 2'd3, 2'd0, 1'b0, 3'b000},
      '{32'd9500,       2'd0, 2'd0, 2'd3, 1'b0, 3'b000},
      '{32'd9500,       2'd3, 2'd0, 2'd0, 1'b0, 3'b000},
      '{32'hFFFF_FF00,  2'd3, 2'd0, 2'd0, 1'b0, 3'b000},
      '{32'hFFFF_FF80,  2'd0, 2'd3, 2'd0, 1'b0, 3'b000},
      '{32'h0000_0010,  2'd0, 2'd0, 2'd3, 1'b0, 3'b000},
      '{32'hFFFF_FFFF,  2'd3, 2'd3, 2'd3, 1'b0, 3'b000},
      '{32'h8000_0FB0,  2'd0, 2'd0, 2'd0, 1'b0, 3'b000},
      '{32'h8000_0FAF,  2'd2, 2'd1, 2'd3, 1'b0, 3'b000}
   };

   ordered_touch_stroke_detector_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic is_before(input logic [TimeWidth-1:0] x,
                                      input logic [TimeWidth-1:0] y);
      logic [TimeWidth-1:0] delta;
      delta = x - y;
      return delta[TimeWidth-1];
   endfunction

   function automatic void drop_gesture();
      for (int z = 0; z < ZoneCount; z++) begin
         zone_time[z] = '0;
      end
      zone_hit = '0;
   endfunction

   function automatic rsp_payload_type judge_sample(input req_payload_type s);
      rsp_payload_type       verdict;
      logic [LevelWidth-1:0] lv [ZoneCount];
      logic [TimeWidth-1:0]  quiet;
      logic                  fwd;
      logic                  rev;
      verdict = '0;
      lv[0] = s.front_level;
      lv[1] = s.middle_level;
      lv[2] = s.rear_level;
      if (cooling) begin
         if (is_before(s.sample_time, cool_until)) begin
            verdict.sample_ignored = 1'b1;
            return verdict;
         end
         cooling = 1'b0;
      end
      quiet = s.sample_time - last_touch;
      if (quiet > {16'd0, gap_ms}) begin
         drop_gesture();
      end
      if ((lv[0] | lv[1] | lv[2]) != '0) begin
         last_touch = s.sample_time;
      end
      for (int z = 0; z < ZoneCount; z++) begin
         if (lv[z] >= peak_lvl && !zone_hit[z]) begin
            zone_time[z] = s.sample_time;
            zone_hit[z] = 1'b1;
         end
      end
      if (zone_hit == AllZonesHit) begin
         fwd = !is_before(zone_time[1], zone_time[0]) && !is_before(zone_time[2], zone_time[1])
               && is_before(zone_time[0], zone_time[2]);
         rev = !is_before(zone_time[0], zone_time[1]) && !is_before(zone_time[1], zone_time[2])
               && is_before(zone_time[2], zone_time[0]);
         drop_gesture();
         if (fwd || rev) begin
            verdict.stroke_found = 1'b1;
            verdict.direction = !fwd;
            last_touch = '0;
            cool_until = s.sample_time + {16'd0, cool_ms};
            cooling = 1'b1;
         end
      end
      return verdict;
   endfunction

   function automatic logic [TimeWidth-1:0] pace_step();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) return '0;
      if (roll < 85) return $urandom_range(gap_ms / 2 + 1);
      if (roll < 95) return gap_ms + 1 + $urandom_range(50);
      return $urandom_range(gap_ms);
   endfunction

   task automatic flag_mismatch(input string field, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= 100) begin
         $display("mismatch at transaction %0d, %s: got %0d, expected %0d",
                  result_count, field, got, want);
      end
   endtask

   task automatic offer_sample(input req_payload_type item, input logic known,
                               input rsp_payload_type typed);
      rsp_payload_type predicted;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = judge_sample(item);
      pending_verdicts.push_back(known ? typed : predicted);
      if (!predicted.sample_ignored) live_count++;
      @(negedge clock);
   endtask

   task automatic settle_and_program(input logic [LevelWidth-1:0] peak,
                                     input logic [SpanWidth-1:0] gap,
                                     input logic [SpanWidth-1:0] cool);
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CsrPeakLevel;
      csr_write_data <= {{(SpanWidth-LevelWidth){1'b0}}, peak};
      @(negedge clock);
      csr_index <= CsrGapTime;
      csr_write_data <= gap;
      @(negedge clock);
      csr_index <= CsrCooldownTime;
      csr_write_data <= cool;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      peak_lvl = peak;
      gap_ms = gap;
      cool_ms = cool;
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left = 80;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         result_count++;
         if (pending_verdicts.size() == 0) begin
            flag_mismatch("transaction with nothing pending", int'(rsp_payload), -1);
         end else begin
            oldest_verdict = pending_verdicts.pop_front();
            if (rsp_payload.stroke_found !== oldest_verdict.stroke_found)
               flag_mismatch("stroke_found", rsp_payload.stroke_found,
                             oldest_verdict.stroke_found);
            if (rsp_payload.direction !== oldest_verdict.direction)
               flag_mismatch("direction", rsp_payload.direction, oldest_verdict.direction);
            if (rsp_payload.sample_ignored !== oldest_verdict.sample_ignored)
               flag_mismatch("sample_ignored", rsp_payload.sample_ignored,
                             oldest_verdict.sample_ignored);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("ordered_touch_stroke_detector_top_tb: done, errors");
         $finish;
      end
   end

   initial begin
      req_payload_type       item;
      logic [TimeWidth-1:0]  stamp;
      logic [LevelWidth-1:0] lv [ZoneCount];
      logic                  backward;
      logic                  paused;
      int                    zone;
      int                    extra;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_write_enable = 1'b0;
      csr_index = CsrPeakLevel;
      csr_write_data = '0;
      peak_lvl = PeakLevelReset;
      gap_ms = GapTimeReset;
      cool_ms = CooldownTimeReset;
      drop_gesture();
      last_touch = '0;
      cool_until = '0;
      cooling = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (opening_script[i]) begin
         item.sample_time = opening_script[i].at_ms;
         item.front_level = opening_script[i].front;
         item.middle_level = opening_script[i].middle;
         item.rear_level = opening_script[i].rear;
         offer_sample(item, opening_script[i].known, opening_script[i].outcome);
      end

      stamp = 32'h0001_0000;
      for (int phase = 0; phase < PhaseCount; phase++) begin
         settle_and_program(peak_plan[phase], gap_plan[phase], cool_plan[phase]);
         idle_pct = (phase % 4 == 1) ? 63 : (phase % 4 == 3) ? 19 : 0;
         stall_pct = (phase % 4 == 2) ? 63 : (phase % 4 == 3) ? 19 : 0;
         if (phase == 0) hold_request = 1'b1;
         paused = 1'b0;
         live_count = 0;
         while (live_count < LiveTarget) begin
            if (phase == 1 && !paused && live_count >= LiveTarget / 2) begin
               paused = 1'b1;
               req_valid <= 1'b0;
               while (pending_verdicts.size() != 0) @(negedge clock);
            end
            if ($urandom_range(99) < 15) begin
               item.sample_time = $urandom();
               item.front_level = $urandom_range(3);
               item.middle_level = $urandom_range(3);
               item.rear_level = $urandom_range(3);
               offer_sample(item, 1'b0, '0);
            end else begin
               backward = $urandom_range(1);
               for (int k = 0; k < ZoneCount; k++) begin
                  zone = backward ? ZoneCount - 1 - k : k;
                  extra = $urandom_range(2);
                  for (int n = 0; n <= extra; n++) begin
                     stamp += pace_step();
                     for (int z = 0; z < ZoneCount; z++) begin
                        lv[z] = ($urandom_range(99) < 75) ? 2'd0 : 2'($urandom_range(3));
                     end
                     if (n == extra) lv[zone] = 2'($urandom_range(3, peak_lvl));
                     item.sample_time = stamp;
                     item.front_level = lv[0];
                     item.middle_level = lv[1];
                     item.rear_level = lv[2];
                     offer_sample(item, 1'b0, '0);
                  end
               end
               if ($urandom_range(99) < 80) stamp += cool_ms + $urandom_range(300, 1);
               else stamp += $urandom_range(cool_ms);
            end
         end
      end

      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("ordered_touch_stroke_detector_top_tb: done, clean");
      end else begin
         $display("ordered_touch_stroke_detector_top_tb: done, errors");
      end
      $finish;
   end

endmodule
